FILE: rtl/ccb0_pkg.sv
// ----------------------------------------------------------------------------
// ccb0_pkg
// Shared types, constants and helpers for the eight-bit core subset.
// ----------------------------------------------------------------------------
package ccb0_pkg;

  localparam int unsigned NumGpRegs = 7;
  localparam logic [2:0]  RegA      = 3'd6;
  localparam logic [1:0]  PairHl    = 2'd2;
  localparam logic [1:0]  PairSp    = 2'd3;

  // flag positions in the Z,N,H,C nibble
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // opcodes with dedicated handling
  localparam logic [7:0] OpNop    = 8'h00;
  localparam logic [7:0] OpLdA16Sp = 8'h08;
  localparam logic [7:0] OpRlca   = 8'h07;
  localparam logic [7:0] OpRrca   = 8'h0F;
  localparam logic [7:0] OpRla    = 8'h17;
  localparam logic [7:0] OpRra    = 8'h1F;
  localparam logic [7:0] OpDaa    = 8'h27;
  localparam logic [7:0] OpCpl    = 8'h2F;
  localparam logic [7:0] OpScf    = 8'h37;
  localparam logic [7:0] OpCcf    = 8'h3F;
  localparam logic [7:0] OpIncHlm = 8'h34;
  localparam logic [7:0] OpDecHlm = 8'h35;
  localparam logic [7:0] OpLdHlmN = 8'h36;

  // low-nibble opcode groups
  localparam logic [3:0] LoLd16   = 4'h1;
  localparam logic [3:0] LoStInd  = 4'h2;
  localparam logic [3:0] LoInc16  = 4'h3;
  localparam logic [3:0] LoAdd16  = 4'h9;
  localparam logic [3:0] LoLdInd  = 4'hA;
  localparam logic [3:0] LoDec16  = 4'hB;

  typedef struct packed {
    logic [NumGpRegs-1:0][7:0] gp;
    logic [3:0]                flags;
    logic [15:0]               sp;
    logic [15:0]               pc;
    logic [7:0]                op;
    logic [2:0]                mc;
    logic [15:0]               imm;
    logic                      first;
  } core_state_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        fetch;
    logic        unimpl;
    logic [7:0]  acc;
    logic [3:0]  flags;
  } bus_result_t;

  // read a register pair: BC, DE, HL or SP
  function automatic logic [15:0] get16(core_state_t st, logic [1:0] sel);
    logic [15:0] v;
    case (sel)
      PairSp:  v = st.sp;
      default: v = {st.gp[{sel, 1'b0}], st.gp[{sel, 1'b1}]};
    endcase
    return v;
  endfunction

  // write a register pair
  function automatic core_state_t put16(core_state_t st, logic [1:0] sel, logic [15:0] v);
    core_state_t s;
    s = st;
    case (sel)
      PairSp: s.sp = v;
      default: begin
        s.gp[{sel, 1'b0}] = v[15:8];
        s.gp[{sel, 1'b1}] = v[7:0];
      end
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/ccb0_exec.sv
// ----------------------------------------------------------------------------
// ccb0_exec
// Next-state and bus access logic for one machine cycle.
// ----------------------------------------------------------------------------
module ccb0_exec import ccb0_pkg::*; (
  input  core_state_t cur_i,
  input  logic [7:0]  read_data_i,
  input  logic [15:0] start_pc_i,
  output core_state_t nxt_o,
  output bus_result_t res_o
);

  always_comb begin
    core_state_t s;
    bus_result_t r;
    logic [7:0]  op;
    logic [3:0]  lo;
    logic [1:0]  sel;
    logic [2:0]  n;
    logic [2:0]  ri;
    logic [15:0] hl;
    logic [15:0] rr;
    logic [16:0] sum;
    logic [12:0] hsum;
    logic [7:0]  a;
    logic [7:0]  v;
    logic [7:0]  t;
    logic        c;
    logic        fetch_en;
    logic        imm_en;
    logic        unsup;
    logic        one_cyc;

    s = cur_i;
    r = '0;
    // a cycle without a memory access presents a read of pc
    r.addr = cur_i.pc;
    fetch_en = 1'b0;
    imm_en = 1'b0;
    op = (cur_i.mc == 3'd0) ? read_data_i : cur_i.op;
    lo = op[3:0];
    sel = op[5:4];
    n = cur_i.mc + 3'd1;
    ri = (op[5:3] >= RegA) ? RegA : op[5:3];
    hl = get16(cur_i, PairHl);
    rr = get16(cur_i, sel);
    a = cur_i.gp[RegA];
    c = cur_i.flags[FlagC];
    sum = 17'(hl) + 17'(rr);
    hsum = 13'(hl[11:0]) + 13'(rr[11:0]);
    v = cur_i.gp[ri];
    t = a;
    unsup = (op[7:6] != 2'b00) || ((op[2:0] == 3'd0) && (op[5:4] != 2'b00));
    one_cyc = (op == OpNop) || (op[2:0] == 3'd7) ||
              (((op[2:0] == 3'd4) || (op[2:0] == 3'd5)) && (op != OpIncHlm) && (op != OpDecHlm));

    if (cur_i.first) begin
      // first cycle after reset: fetch at the start address
      s.first = 1'b0;
      s.pc = start_pc_i;
      fetch_en = 1'b1;
    end else begin
      s.op = op;
      if (unsup) begin
        s.mc = 3'd1;
        r.unimpl = 1'b1;
      end else begin
        s.mc = n;
        if (one_cyc) begin
          fetch_en = 1'b1;
          case (op)
            OpRlca: begin
              s.gp[RegA] = {a[6:0], a[7]};
              s.flags = {3'b000, a[7]};
            end
            OpRrca: begin
              s.gp[RegA] = {a[0], a[7:1]};
              s.flags = {3'b000, a[0]};
            end
            OpRla: begin
              s.gp[RegA] = {a[6:0], c};
              s.flags = {3'b000, a[7]};
            end
            OpRra: begin
              s.gp[RegA] = {c, a[7:1]};
              s.flags = {3'b000, a[0]};
            end
            OpDaa: begin
              // decimal adjust, tested on A before the correction
              if (!cur_i.flags[FlagN]) begin
                if (c || (a > 8'h99)) begin
                  t = t + 8'h60;
                  s.flags[FlagC] = 1'b1;
                end
                if (cur_i.flags[FlagH] || (a[3:0] > 4'd9)) t = t + 8'h06;
              end else begin
                if (c) t = t - 8'h60;
                if (cur_i.flags[FlagH]) t = t - 8'h06;
              end
              s.gp[RegA] = t;
              s.flags[FlagZ] = (t == 8'h00);
              s.flags[FlagH] = 1'b0;
            end
            OpCpl: begin
              s.gp[RegA] = ~a;
              s.flags[FlagN] = 1'b1;
              s.flags[FlagH] = 1'b1;
            end
            OpScf: begin
              s.flags[FlagC] = 1'b1;
              s.flags[FlagN] = 1'b0;
              s.flags[FlagH] = 1'b0;
            end
            OpCcf: begin
              s.flags[FlagC] = ~c;
              s.flags[FlagN] = 1'b0;
              s.flags[FlagH] = 1'b0;
            end
            default: begin
              // 8-bit inc and dec
              if (op[2:0] == 3'd4) begin
                t = v + 8'd1;
                s.gp[ri] = t;
                s.flags[FlagZ] = (t == 8'h00);
                s.flags[FlagN] = 1'b0;
                s.flags[FlagH] = (v[3:0] == 4'hF);
              end else if (op[2:0] == 3'd5) begin
                t = v - 8'd1;
                s.gp[ri] = t;
                s.flags[FlagZ] = (t == 8'h00);
                s.flags[FlagN] = 1'b1;
                s.flags[FlagH] = (v[3:0] == 4'h0);
              end
            end
          endcase
        end else if (lo == LoLd16) begin
          if (n == 3'd1) imm_en = 1'b1;
          else if (n == 3'd2) begin
            s.imm = {8'h00, read_data_i};
            imm_en = 1'b1;
          end else begin
            s.imm = {read_data_i, cur_i.imm[7:0]};
            s = put16(s, sel, s.imm);
            fetch_en = 1'b1;
          end
        end else if (lo == LoStInd || lo == LoLdInd) begin
          if (n == 3'd1) begin
            r.wr = (lo == LoStInd);
            r.wdata = (lo == LoStInd) ? a : 8'h00;
            if (!sel[1]) r.addr = rr;
            else begin
              r.addr = hl;
              s = put16(s, PairHl, sel[0] ? hl - 16'd1 : hl + 16'd1);
            end
          end else begin
            if (lo == LoLdInd) s.gp[RegA] = read_data_i;
            fetch_en = 1'b1;
          end
        end else if (op == OpLdA16Sp) begin
          if (n == 3'd1) imm_en = 1'b1;
          else if (n == 3'd2) begin
            s.imm = {8'h00, read_data_i};
            imm_en = 1'b1;
          end else if (n == 3'd3) begin
            r.wr = 1'b1;
            r.addr = {read_data_i, cur_i.imm[7:0]};
            r.wdata = cur_i.sp[7:0];
            s.imm = {read_data_i, cur_i.imm[7:0]} + 16'd1;
          end else if (n == 3'd4) begin
            r.wr = 1'b1;
            r.addr = cur_i.imm;
            r.wdata = cur_i.sp[15:8];
          end else fetch_en = 1'b1;
        end else if (lo == LoInc16 || lo == LoDec16) begin
          if (n == 3'd1) s = put16(s, sel, (lo == LoInc16) ? rr + 16'd1 : rr - 16'd1);
          else fetch_en = 1'b1;
        end else if (lo == LoAdd16) begin
          if (n == 3'd1) begin
            s.flags[FlagN] = 1'b0;
            s.flags[FlagH] = hsum[12];
            s.flags[FlagC] = sum[16];
            s = put16(s, PairHl, sum[15:0]);
          end else fetch_en = 1'b1;
        end else if (op == OpIncHlm || op == OpDecHlm) begin
          if (n == 3'd1) r.addr = hl;
          else if (n == 3'd2) begin
            r.wr = 1'b1;
            r.addr = hl;
            if (op == OpIncHlm) begin
              t = read_data_i + 8'd1;
              s.flags[FlagN] = 1'b0;
              s.flags[FlagH] = (read_data_i[3:0] == 4'hF);
            end else begin
              t = read_data_i - 8'd1;
              s.flags[FlagN] = 1'b1;
              s.flags[FlagH] = (read_data_i[3:0] == 4'h0);
            end
            s.flags[FlagZ] = (t == 8'h00);
            r.wdata = t;
          end else fetch_en = 1'b1;
        end else if (op == OpLdHlmN) begin
          if (n == 3'd1) imm_en = 1'b1;
          else if (n == 3'd2) begin
            r.wr = 1'b1;
            r.addr = hl;
            r.wdata = read_data_i;
          end else fetch_en = 1'b1;
        end else begin
          // ld r8,n
          if (n == 3'd1) imm_en = 1'b1;
          else begin
            s.gp[ri] = read_data_i;
            fetch_en = 1'b1;
          end
        end
      end
    end

    // program counter reads: immediate byte or next opcode
    if (fetch_en || imm_en) begin
      r.addr = s.pc;
      s.pc = s.pc + 16'd1;
    end
    if (fetch_en) begin
      r.fetch = 1'b1;
      s.mc = 3'd0;
    end

    r.acc = s.gp[RegA];
    r.flags = s.flags;
    nxt_o = s;
    res_o = r;
  end

endmodule

FILE: rtl/cpu_core_block0_opcodes.sv
// ----------------------------------------------------------------------------
// cpu_core_block0_opcodes
// Eight-bit core subset, one machine cycle per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries the byte read at the address of the previous
// result and advances the core by one machine cycle, producing one
// registered result transfer: this cycle's bus access plus A and the flags.
// One transfer per clock is sustained unless the result side stalls; the
// whole cycle is evaluated between the core state registers and the output
// register, and a new input is taken in the same clock in which the waiting
// result leaves. After reset the first result is the opcode fetch at start_pc;
// an unsupported opcode holds the core until reset with unimplemented set.
module cpu_core_block0_opcodes import ccb0_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_pc_we_i,
  input  logic [15:0] start_pc_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] bus_addr_o,
  output logic        bus_write_o,
  output logic [7:0]  bus_wdata_o,
  output logic        opcode_fetch_o,
  output logic        unimplemented_o,
  output logic [7:0]  acc_value_o,
  output logic [3:0]  flag_bits_o
);

  logic [15:0] start_pc_q;
  core_state_t state_q, state_d;
  bus_result_t res_d, res_q;
  logic        out_valid_q;
  logic        in_xfer;

  ccb0_exec u_exec (
    .cur_i       (state_q),
    .read_data_i (read_data_i),
    .start_pc_i  (start_pc_q),
    .nxt_o       (state_d),
    .res_o       (res_d)
  );

  // input transfer whenever the output register is free or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q <= '0;
    end else if (start_pc_we_i) begin
      start_pc_q <= start_pc_i;
    end
  end

  // core state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{first: 1'b1, default: '0};
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign bus_addr_o      = res_q.addr;
  assign bus_write_o     = res_q.wr;
  assign bus_wdata_o     = res_q.wdata;
  assign opcode_fetch_o  = res_q.fetch;
  assign unimplemented_o = res_q.unimpl;
  assign acc_value_o     = res_q.acc;
  assign flag_bits_o     = res_q.flags;

endmodule

FILE: bench/cpu_core_block0_opcodes_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_core_block0_opcodes_test
// Feeds the core a byte stream that behaves like memory: whenever the last
// predicted cycle fetched an opcode the next byte is a chosen opcode,
// otherwise it is operand or load data. A cycle-level predictor of the core
// computes each expected bus cycle, and every result transfer is checked
// against it field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module cpu_core_block0_opcodes_test;
  import ccb0_pkg::*;

  localparam int          NumRandom = 900;
  localparam int          IdleLimit = 2000;
  localparam logic [2:0]  LoInc8    = 3'd4;
  localparam logic [2:0]  LoDec8    = 3'd5;
  localparam logic [2:0]  LoAlu     = 3'd7;

  typedef enum int {PhDirected, PhRandom, PhBadOp} phase_e;

  // core predictor and queue of expected bus cycles
  class core_scoreboard;
    logic [15:0]  start_pc;
    logic [7:0]   regs [NumGpRegs];
    logic [3:0]   flg;
    logic [15:0]  sp;
    logic [15:0]  pc;
    logic [7:0]   op;
    int           mc;
    logic [15:0]  imm;
    bit           first;
    bit           last_fetch;
    bus_result_t  cur;
    bus_result_t  expected_cycles [$];
    int           errors;

    function new();
      start_pc = '0;
      foreach (regs[i]) regs[i] = '0;
      flg = '0; sp = '0; pc = '0; op = '0; mc = 0; imm = '0;
      first = 1'b1; last_fetch = 1'b0; errors = 0;
    endfunction

    function logic [15:0] pair_rd(logic [1:0] sel);
      if (sel == PairSp) return sp;
      return {regs[{sel, 1'b0}], regs[{sel, 1'b1}]};
    endfunction

    function void pair_wr(logic [1:0] sel, logic [15:0] v);
      if (sel == PairSp) sp = v;
      else begin
        regs[{sel, 1'b0}] = v[15:8];
        regs[{sel, 1'b1}] = v[7:0];
      end
    endfunction

    function logic [7:0] inc8(logic [7:0] v);
      logic [7:0] r;
      r = v + 8'd1;
      flg[FlagZ] = (r == 8'd0);
      flg[FlagN] = 1'b0;
      flg[FlagH] = (v[3:0] == 4'hF);
      return r;
    endfunction

    function logic [7:0] dec8(logic [7:0] v);
      logic [7:0] r;
      r = v - 8'd1;
      flg[FlagZ] = (r == 8'd0);
      flg[FlagN] = 1'b1;
      flg[FlagH] = (v[3:0] == 4'h0);
      return r;
    endfunction

    function int r8(logic [7:0] o);
      return (o[5:3] >= RegA) ? int'(RegA) : int'(o[5:3]);
    endfunction

    function void fetch();
      cur.addr = pc;
      cur.fetch = 1'b1;
      pc = pc + 16'd1;
      mc = 0;
    endfunction

    function void read_imm();
      cur.addr = pc;
      pc = pc + 16'd1;
    endfunction

    function void mem_wr(logic [15:0] a, logic [7:0] v);
      cur.addr = a;
      cur.wr = 1'b1;
      cur.wdata = v;
    endfunction

    // decimal adjust, decided on A before adjustment
    function void daa();
      logic [7:0] a;
      a = regs[RegA];
      if (!flg[FlagN]) begin
        if (flg[FlagC] || a > 8'h99) begin
          a = a + 8'h60;
          flg[FlagC] = 1'b1;
        end
        if (flg[FlagH] || a[3:0] > 4'd9) a = a + 8'h06;
      end else begin
        if (flg[FlagC]) a = a - 8'h60;
        if (flg[FlagH]) a = a - 8'h06;
      end
      regs[RegA] = a;
      flg[FlagZ] = (a == 8'd0);
      flg[FlagH] = 1'b0;
    endfunction

    function void single_op(logic [7:0] o);
      logic [7:0] a;
      logic       c;
      logic       nc;
      int         i;
      a = regs[RegA];
      c = flg[FlagC];
      case (o)
        OpRlca: begin c = a[7]; a = {a[6:0], c}; end
        OpRrca: begin c = a[0]; a = {c, a[7:1]}; end
        OpRla: begin nc = a[7]; a = {a[6:0], c}; c = nc; end
        OpRra: begin nc = a[0]; a = {c, a[7:1]}; c = nc; end
        OpDaa: begin daa(); return; end
        OpCpl: begin
          regs[RegA] = ~a;
          flg[FlagN] = 1'b1;
          flg[FlagH] = 1'b1;
          return;
        end
        OpScf: begin
          flg[FlagC] = 1'b1; flg[FlagN] = 1'b0; flg[FlagH] = 1'b0;
          return;
        end
        OpCcf: begin
          flg[FlagC] = ~c; flg[FlagN] = 1'b0; flg[FlagH] = 1'b0;
          return;
        end
        default: begin
          i = r8(o);
          if (o[2:0] == LoInc8) regs[i] = inc8(regs[i]);
          else if (o[2:0] == LoDec8) regs[i] = dec8(regs[i]);
          return;
        end
      endcase
      regs[RegA] = a;
      flg = '0;
      flg[FlagC] = c;
    endfunction

    function bit one_cycle(logic [7:0] o);
      if (o == OpNop) return 1'b1;
      if ((o[2:0] == LoInc8 || o[2:0] == LoDec8) && o != OpIncHlm && o != OpDecHlm)
        return 1'b1;
      return o[2:0] == LoAlu;
    endfunction

    function bit unsupported(logic [7:0] o);
      return (o[7:6] != 2'b00) || (o[2:0] == 3'd0 && o[5:4] != 2'b00);
    endfunction

    // one machine cycle of a supported instruction
    function void exec(logic [7:0] d);
      logic [3:0]  lo;
      logic [1:0]  sel;
      logic [15:0] hl;
      logic [15:0] r;
      logic [16:0] s;
      logic [12:0] hs;
      lo = op[3:0];
      sel = op[5:4];
      hl = pair_rd(PairHl);
      if (one_cycle(op)) begin
        if (op != OpNop) single_op(op);
        fetch();
      end else if (lo == LoLd16) begin
        if (mc == 1) read_imm();
        else if (mc == 2) begin imm = {8'd0, d}; read_imm(); end
        else begin imm = {d, imm[7:0]}; pair_wr(sel, imm); fetch(); end
      end else if (lo == LoStInd) begin
        if (mc == 1) begin
          if (sel < PairHl) mem_wr(pair_rd(sel), regs[RegA]);
          else begin
            mem_wr(hl, regs[RegA]);
            pair_wr(PairHl, sel == PairHl ? hl + 16'd1 : hl - 16'd1);
          end
        end else fetch();
      end else if (lo == LoLdInd) begin
        if (mc == 1) begin
          if (sel < PairHl) cur.addr = pair_rd(sel);
          else begin
            cur.addr = hl;
            pair_wr(PairHl, sel == PairHl ? hl + 16'd1 : hl - 16'd1);
          end
        end else begin regs[RegA] = d; fetch(); end
      end else if (op == OpLdA16Sp) begin
        if (mc == 1) read_imm();
        else if (mc == 2) begin imm = {8'd0, d}; read_imm(); end
        else if (mc == 3) begin
          imm = {d, imm[7:0]};
          mem_wr(imm, sp[7:0]);
          imm = imm + 16'd1;
        end else if (mc == 4) mem_wr(imm, sp[15:8]);
        else fetch();
      end else if (lo == LoInc16 || lo == LoDec16) begin
        if (mc == 1) pair_wr(sel, lo == LoInc16 ? pair_rd(sel) + 16'd1 : pair_rd(sel) - 16'd1);
        else fetch();
      end else if (lo == LoAdd16) begin
        if (mc == 1) begin
          r = pair_rd(sel);
          s = {1'b0, hl} + {1'b0, r};
          hs = {1'b0, hl[11:0]} + {1'b0, r[11:0]};
          flg[FlagN] = 1'b0;
          flg[FlagH] = hs[12];
          flg[FlagC] = s[16];
          pair_wr(PairHl, s[15:0]);
        end else fetch();
      end else if (op == OpIncHlm || op == OpDecHlm) begin
        if (mc == 1) cur.addr = hl;
        else if (mc == 2) mem_wr(hl, op == OpIncHlm ? inc8(d) : dec8(d));
        else fetch();
      end else if (op == OpLdHlmN) begin
        if (mc == 1) read_imm();
        else if (mc == 2) mem_wr(hl, d);
        else fetch();
      end else begin
        if (mc == 1) read_imm();
        else begin regs[r8(op)] = d; fetch(); end
      end
    endfunction

    // accepted input byte: advance one machine cycle
    function void note_input(logic [7:0] d);
      cur = '0;
      cur.addr = pc;
      if (first) begin
        first = 1'b0;
        pc = start_pc;
        fetch();
      end else begin
        if (mc == 0) op = d;
        if (unsupported(op)) begin
          mc = 1;
          cur.addr = pc;
          cur.unimpl = 1'b1;
        end else begin
          mc = (mc + 1) & 7;
          exec(d);
        end
      end
      cur.acc = regs[RegA];
      cur.flags = flg;
      last_fetch = cur.fetch;
      expected_cycles.push_back(cur);
    endfunction

    function void check_result(bus_result_t got);
      bus_result_t exp;
      if (expected_cycles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      exp = expected_cycles.pop_front();
      if (got.addr !== exp.addr || got.wr !== exp.wr || got.wdata !== exp.wdata ||
          got.fetch !== exp.fetch || got.unimpl !== exp.unimpl ||
          got.acc !== exp.acc || got.flags !== exp.flags) begin
        errors++;
        if (errors <= 10) $display("bus cycle mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_pc_we_i = 1'b0;
  logic [15:0] start_pc_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  read_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [15:0] bus_addr_o;
  logic        bus_write_o;
  logic [7:0]  bus_wdata_o;
  logic        opcode_fetch_o;
  logic        unimplemented_o;
  logic [7:0]  acc_value_o;
  logic [3:0]  flag_bits_o;

  core_scoreboard sb = new();
  phase_e         phase = PhDirected;
  logic [7:0]     good_ops [$];
  int             dir_op_idx = 0;
  int             dir_data_idx = 0;
  bit             bad_sent = 1'b0;
  bit             in_burst = 1'b0;
  bit             out_burst = 1'b0;
  int             idle_cycles = 0;

  // directed opcodes: flag edges, daa after a subtraction, and the (hl), (hl+), (hl-) and (a16) forms
  logic [7:0] dir_ops [] = '{8'h3E, 8'h3C, 8'h3D, 8'h27, 8'h3E, 8'h27, 8'h2F, 8'h37,
                             8'h3F, 8'h07, 8'h0F, 8'h17, 8'h1F, 8'h21, 8'h29, 8'h31,
                             8'h39, 8'h08, 8'h34, 8'h35, 8'h36, 8'h22, 8'h32, 8'h2A,
                             8'h3A, 8'h0B, 8'h00};
  logic [7:0] dir_data [] = '{8'hFF, 8'h9A, 8'h00, 8'h80, 8'h0F, 8'h01, 8'h99, 8'hF0};

  cpu_core_block0_opcodes dut (
    .clk_i, .rst_ni, .start_pc_we_i, .start_pc_i,
    .in_valid_i, .in_stall_o, .read_data_i,
    .out_valid_o, .out_stall_i,
    .bus_addr_o, .bus_write_o, .bus_wdata_o, .opcode_fetch_o,
    .unimplemented_o, .acc_value_o, .flag_bits_o
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // next byte the memory returns, depending on whether an opcode is due
  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    if (phase == PhDirected) begin
      if (sb.last_fetch && dir_op_idx < dir_ops.size()) begin
        b = dir_ops[dir_op_idx];
        dir_op_idx++;
      end else begin
        b = dir_data[dir_data_idx % dir_data.size()];
        dir_data_idx++;
      end
    end else if (sb.last_fetch && phase == PhBadOp && !bad_sent) begin
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b00) b = 8'h10 + 8'(8 * $urandom_range(0, 5));
      bad_sent = 1'b1;
    end else if (sb.last_fetch) begin
      b = good_ops[$urandom_range(0, good_ops.size() - 1)];
    end else b = rand_data();
    return b;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_byte();
    int gap;
    gap = draw_gap(in_burst);
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    read_data_i <= next_byte();
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // wait for all results, let the core settle, then load start_pc
  task automatic write_start_pc(logic [15:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_cycles.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    start_pc_we_i <= 1'b1;
    start_pc_i <= v;
    sb.start_pc = v;
    @(negedge clk_i);
    start_pc_we_i <= 1'b0;
  endtask

  // result side stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = draw_gap(out_burst);
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    bus_result_t got;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        got = '{bus_addr_o, bus_write_o, bus_wdata_o, opcode_fetch_o,
                unimplemented_o, acc_value_o, flag_bits_o};
        sb.check_result(got);
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(read_data_i);
        moved = 1'b1;
      end
      if (moved) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    for (int o = 0; o < 64; o++)
      if (!sb.unsupported(8'(o))) good_ops.push_back(8'(o));
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first fetch from the top of memory, so pc wraps
    write_start_pc(16'hFFFF);
    while (dir_op_idx < dir_ops.size()) send_byte();

    phase = PhRandom;
    write_start_pc(16'h0000);
    repeat (NumRandom / 3) send_byte();
    write_start_pc(16'($urandom_range(0, 65535)));
    repeat (NumRandom / 3) send_byte();
    write_start_pc(16'h8001);
    repeat (NumRandom / 3) send_byte();

    // an unsupported opcode parks the core for the rest of the run
    phase = PhBadOp;
    while (!bad_sent) send_byte();
    repeat (6) send_byte();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.expected_cycles.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_cycles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: cpu_core_block0_opcodes.f
rtl/ccb0_pkg.sv
rtl/ccb0_exec.sv
rtl/cpu_core_block0_opcodes.sv
bench/cpu_core_block0_opcodes_test.sv
